>>> rtl/core/tbero_pkg.sv
// Package for the threshold and binary erosion block.
// Holds register indexes, reset values, fixed field widths and the config struct.
// No dependencies.
package tbero_pkg;

  localparam int unsigned MaxWidthDef = 1024;
  localparam int unsigned WindowDef   = 5;
  localparam int unsigned MaxHeight   = 1024;

  localparam int unsigned PixW    = 8;
  localparam int unsigned CoordW  = 10;
  localparam int unsigned DimW    = 11;
  localparam int unsigned CfgW    = 11;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegThreshold       = 3'd0;
  localparam logic [CfgIdxW-1:0] RegFrameWidth      = 3'd1;
  localparam logic [CfgIdxW-1:0] RegFrameHeight     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegObjectValue     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBackgroundValue = 3'd4;

  localparam logic [PixW-1:0] ThresholdRst       = 8'd205;
  localparam logic [DimW-1:0] FrameWidthRst      = 11'd1024;
  localparam logic [DimW-1:0] FrameHeightRst     = 11'd1024;
  localparam logic [PixW-1:0] ObjectValueRst     = 8'd255;
  localparam logic [PixW-1:0] BackgroundValueRst = 8'd0;

  typedef struct packed {
    logic [DimW-1:0] height_eff;
    logic [PixW-1:0] object_value;
    logic [PixW-1:0] background_value;
  } out_cfg_t;

endpackage

>>> rtl/core/tbero_px_in_if.sv
// Input pixel channel: valid/ready handshake with gray level and frame start.
// Depends on tbero_pkg.
interface tbero_px_in_if;
  import tbero_pkg::*;

  logic            valid;
  logic            ready;
  logic [PixW-1:0] gray_pixel;
  logic            start_frame;

  modport source (output valid, output gray_pixel, output start_frame, input ready);
  modport sink   (input valid, input gray_pixel, input start_frame, output ready);
endinterface

>>> rtl/core/tbero_px_out_if.sv
// Output pixel channel: valid/ready handshake with the eroded pixel and its position.
// Depends on tbero_pkg.
interface tbero_px_out_if;
  import tbero_pkg::*;

  logic              valid;
  logic              ready;
  logic              out_valid;
  logic [PixW-1:0]   out_pixel;
  logic [CoordW-1:0] out_col;
  logic [CoordW-1:0] out_row;

  modport source (output valid, output out_valid, output out_pixel, output out_col,
                  output out_row, input ready);
  modport sink   (input valid, input out_valid, input out_pixel, input out_col,
                  input out_row, output ready);
endinterface

>>> rtl/core/tbero_line_mem.sv
// Line store: one-write, one-read synchronous memory with registered read data.
// A read that meets a write to the same entry returns the new data. No package use.
module tbero_line_mem #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned DataW = 4
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [DataW-1:0]         rdata_o,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [DataW-1:0]         wdata_i
);
  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;
endmodule

>>> rtl/core/tbero_window.sv
// Window stage: merges line store data with the new bit, shifts the window,
// writes the line back and holds the result word. Depends on tbero_pkg and tbero_px_out_if.
module tbero_window #(
  parameter int unsigned Window = 5,
  parameter int unsigned ColW   = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  output logic                          ready_o,
  input  logic                          bit_i,
  input  logic [ColW-1:0]               col_i,
  input  logic [tbero_pkg::CoordW-1:0]  row_i,
  input  logic [ColW:0]                 width_eff_i,
  input  tbero_pkg::out_cfg_t           cfg_i,
  input  logic [2*(Window/2)-1:0]       line_i,
  output logic                          mem_we_o,
  output logic [ColW-1:0]               mem_waddr_o,
  output logic [2*(Window/2)-1:0]       mem_wdata_o,
  tbero_px_out_if.source                px_out
);
  import tbero_pkg::*;

  localparam int unsigned Rad   = Window / 2;
  localparam int unsigned Side  = 2 * Rad + 1;
  localparam int unsigned LineW = 2 * Rad;
  localparam int unsigned WinW  = Side * Side;

  logic              s1_valid_q;
  logic              s1_bit_q;
  logic [ColW-1:0]   s1_col_q;
  logic [CoordW-1:0] s1_row_q;
  logic              s1_adv;

  logic [WinW-1:0]   win_q, win_d;
  logic [Side-1:0]   column;
  logic              emit, in_frame, obj;
  logic [ColW-1:0]   oc;
  logic [CoordW-1:0] orow;

  logic              s2_valid_q;
  logic              s2_emit_q;
  logic [PixW-1:0]   s2_pixel_q;
  logic [CoordW-1:0] s2_col_q;
  logic [CoordW-1:0] s2_row_q;

  assign s1_adv  = s1_valid_q && (!s2_valid_q || px_out.ready);
  assign ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept_i) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_bit_q <= bit_i;
      s1_col_q <= col_i;
      s1_row_q <= row_i;
    end
  end

  assign column      = {line_i, s1_bit_q};
  assign win_d       = {win_q[WinW-Side-1:0], column};
  assign mem_we_o    = s1_adv;
  assign mem_waddr_o = s1_col_q;
  assign mem_wdata_o = {line_i[LineW-2:0], s1_bit_q};

  assign emit     = (s1_col_q >= ColW'(Rad)) && (s1_row_q >= CoordW'(Rad));
  assign oc       = s1_col_q - ColW'(Rad);
  assign orow     = s1_row_q - CoordW'(Rad);
  assign in_frame = (oc >= ColW'(Rad)) && (({1'b0, oc} + (ColW+1)'(Rad)) < width_eff_i) &&
                    (orow >= CoordW'(Rad)) &&
                    (({1'b0, orow} + (CoordW+1)'(Rad)) < cfg_i.height_eff);
  assign obj      = in_frame && (&win_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_adv) begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s2_valid_q <= 1'b1;
    end else if (px_out.ready) begin
      s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_emit_q <= emit;
      if (emit) begin
        s2_pixel_q <= obj ? cfg_i.object_value : cfg_i.background_value;
        s2_col_q   <= CoordW'(oc);
        s2_row_q   <= orow;
      end else begin
        s2_pixel_q <= '0;
        s2_col_q   <= '0;
        s2_row_q   <= '0;
      end
    end
  end

  assign px_out.valid     = s2_valid_q;
  assign px_out.out_valid = s2_emit_q;
  assign px_out.out_pixel = s2_pixel_q;
  assign px_out.out_col   = s2_col_q;
  assign px_out.out_row   = s2_row_q;

  a_no_word_on_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && s1_valid_q |-> s1_adv)
    else $error("window stage overwritten while holding a word");

  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> s2_valid_q)
    else $error("advanced word missing from output register");

  a_obj_needs_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && obj |-> emit)
    else $error("object pixel reported without a lagged position");

  a_blank_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && !s2_emit_q |-> (s2_pixel_q == '0) && (s2_col_q == '0) && (s2_row_q == '0))
    else $error("fields not cleared on a word without a lagged pixel");
endmodule

>>> rtl/core/threshold_and_binary_erosion_top.sv
// Top level of the threshold and binary erosion block: config registers, raster
// counters, thresholding, line store and window stage. Depends on tbero_pkg and the channel interfaces.
//
//   channel   direction  word contents
//   px_in     in         gray_pixel, start_frame
//   px_out    out        out_valid, out_pixel, out_col, out_row
//   cfg       in         cfg_we_i, cfg_idx_i, cfg_wdata_i (write only)
//
// One word in and one word out per cycle unless px_out stalls; each word passes both stage registers.
// The line store read issued on accept sets the first stage; the window update sets the second.
// Reset clears counters, window and handshake state; no clearing pass on the line store.
// The output register holds a stalled word while the window stage still takes one more.
module threshold_and_binary_erosion_top #(
  parameter int unsigned MAX_WIDTH = tbero_pkg::MaxWidthDef,
  parameter int unsigned WINDOW    = tbero_pkg::WindowDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tbero_px_in_if.sink                   px_in,
  tbero_px_out_if.source                px_out,
  input  logic                          cfg_we_i,
  input  logic [tbero_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tbero_pkg::CfgW-1:0]    cfg_wdata_i
);
  import tbero_pkg::*;

  localparam int unsigned ColW  = $clog2(MAX_WIDTH);
  localparam int unsigned LineW = 2 * (WINDOW / 2);

  logic [PixW-1:0]   threshold_q;
  logic [DimW-1:0]   frame_width_q;
  logic [DimW-1:0]   frame_height_q;
  logic [PixW-1:0]   object_value_q;
  logic [PixW-1:0]   background_value_q;

  logic [ColW:0]     width_eff;
  logic [DimW-1:0]   height_eff;
  out_cfg_t          out_cfg;

  logic [ColW-1:0]   col_q, col_d, cur_col;
  logic [CoordW-1:0] row_q, row_d, cur_row;
  logic              ready, accept, pix_bit;

  logic [LineW-1:0]  line_rdata, mem_wdata;
  logic [ColW-1:0]   mem_waddr;
  logic              mem_we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q        <= ThresholdRst;
      frame_width_q      <= FrameWidthRst;
      frame_height_q     <= FrameHeightRst;
      object_value_q     <= ObjectValueRst;
      background_value_q <= BackgroundValueRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegThreshold:       threshold_q        <= cfg_wdata_i[PixW-1:0];
        RegFrameWidth:      frame_width_q      <= cfg_wdata_i[DimW-1:0];
        RegFrameHeight:     frame_height_q     <= cfg_wdata_i[DimW-1:0];
        RegObjectValue:     object_value_q     <= cfg_wdata_i[PixW-1:0];
        RegBackgroundValue: background_value_q <= cfg_wdata_i[PixW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (frame_width_q == '0) begin
      width_eff = (ColW+1)'(1);
    end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
      width_eff = (ColW+1)'(MAX_WIDTH);
    end else begin
      width_eff = (ColW+1)'(frame_width_q);
    end
    if (frame_height_q == '0) begin
      height_eff = DimW'(1);
    end else if (32'(frame_height_q) > 32'(MaxHeight)) begin
      height_eff = DimW'(MaxHeight);
    end else begin
      height_eff = frame_height_q;
    end
  end

  assign out_cfg = '{height_eff: height_eff, object_value: object_value_q,
                     background_value: background_value_q};

  assign px_in.ready = ready;
  assign accept      = px_in.valid && ready;
  assign cur_col     = px_in.start_frame ? '0 : col_q;
  assign cur_row     = px_in.start_frame ? '0 : row_q;
  assign pix_bit     = px_in.gray_pixel >= threshold_q;

  always_comb begin
    if (({1'b0, cur_col} + (ColW+1)'(1)) >= width_eff) begin
      col_d = '0;
      if (({1'b0, cur_row} + (CoordW+1)'(1)) >= height_eff) begin
        row_d = '0;
      end else begin
        row_d = cur_row + CoordW'(1);
      end
    end else begin
      col_d = cur_col + ColW'(1);
      row_d = cur_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  tbero_line_mem #(
    .Depth (MAX_WIDTH),
    .DataW (LineW)
  ) u_line_mem (
    .clk_i   (clk_i),
    .re_i    (accept),
    .raddr_i (cur_col),
    .rdata_o (line_rdata),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata)
  );

  tbero_window #(
    .Window (WINDOW),
    .ColW   (ColW)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .ready_o     (ready),
    .bit_i       (pix_bit),
    .col_i       (cur_col),
    .row_i       (cur_row),
    .width_eff_i (width_eff),
    .cfg_i       (out_cfg),
    .line_i      (line_rdata),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .px_out      (px_out)
  );
endmodule
